/* hdl/crcfr_pkg.sv */
package crcfr_pkg;

    localparam logic [7:0]  HEAD_BYTE = 8'hEF;
    localparam logic [7:0]  MIN_LEN   = 8'h04;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_TX      = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_GOOD    = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_HEAD    = 3'd3;
    localparam logic [2:0] ST_LEN     = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] frame_status;
        logic [7:0] msg_type;
        logic [7:0] frame_len;
        logic       last;
    } out_item_t;

    // Work handed from the front to the back. For a status with acknowledge,
    // data carries the sequence number to send back.
    typedef enum logic [1:0] {
        JOB_PAYLOAD    = 2'd0,
        JOB_STATUS     = 2'd1,
        JOB_STATUS_ACK = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic [2:0] status;
        logic [7:0] msg_type;
        logic [7:0] frame_len;
    } job_t;

    // CRC-16 with polynomial 0x1021, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/crcfr_front.sv */
module crcfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crcfr_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              push,
    output crcfr_pkg::job_t   push_job
);
    import crcfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  position_reg, position_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  seq_seen_reg, seq_seen_next;
    logic        seq_valid_reg, seq_valid_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [7:0]  rx_seq_reg, rx_seq_next;

    logic        accept;
    logic [7:0]  b;
    logic [8:0]  len_ext;
    logic [15:0] crc_upd;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign b        = in_data.rx_byte;
    assign len_ext  = {1'b0, length_reg};
    assign crc_upd  = crc_byte(crc_reg, b);

    always_comb
    begin
        phase_next     = phase_reg;
        position_next  = position_reg;
        length_next    = length_reg;
        seq_seen_next  = seq_seen_reg;
        seq_valid_next = seq_valid_reg;
        type_next      = type_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        rx_seq_next    = rx_seq_reg;
        push           = 1'b0;
        push_job       = '0;

        if (accept)
        begin
            if (in_data.opcode)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    push               = 1'b1;
                    push_job.kind      = JOB_STATUS;
                    push_job.status    = ST_TIMEOUT;
                    push_job.msg_type  = type_reg;
                    push_job.frame_len = length_reg;
                    phase_next         = PH_HUNT;
                    position_next      = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        length_next = b;
                        if (b < MIN_LEN)
                        begin
                            push               = 1'b1;
                            push_job.kind      = JOB_STATUS;
                            push_job.status    = ST_LEN;
                            push_job.frame_len = b;
                            phase_next         = PH_HUNT;
                            position_next      = '0;
                        end
                        else
                        begin
                            crc_next      = crc_upd;
                            position_next = 9'd2;
                            phase_next    = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if (position_reg < len_ext)
                        begin
                            crc_next = crc_upd;
                        end
                        if (position_reg == 9'd2)
                        begin
                            rx_seq_next = b;
                        end
                        else if (position_reg == 9'd3)
                        begin
                            type_next = b;
                        end
                        else if (position_reg < len_ext)
                        begin
                            push          = 1'b1;
                            push_job.kind = JOB_PAYLOAD;
                            push_job.data = b;
                        end
                        else if (position_reg == len_ext)
                        begin
                            crc_hi_next = b;
                        end

                        if (position_reg >= len_ext + 9'd1)
                        begin
                            // Frame complete: duplicate test ahead of the CRC test.
                            push               = 1'b1;
                            push_job.msg_type  = type_reg;
                            push_job.frame_len = length_reg;
                            push_job.data      = rx_seq_reg;
                            if (seq_valid_reg && (rx_seq_reg == seq_seen_reg))
                            begin
                                push_job.kind   = JOB_STATUS_ACK;
                                push_job.status = ST_DUP;
                            end
                            else
                            begin
                                seq_seen_next  = rx_seq_reg;
                                seq_valid_next = 1'b1;
                                if ((crc_hi_reg == crc_reg[15:8]) && (b == crc_reg[7:0]))
                                begin
                                    push_job.kind   = JOB_STATUS_ACK;
                                    push_job.status = ST_GOOD;
                                end
                                else
                                begin
                                    push_job.kind   = JOB_STATUS;
                                    push_job.status = ST_CRC;
                                end
                            end
                            phase_next    = PH_HUNT;
                            position_next = '0;
                        end
                        else
                        begin
                            position_next = position_reg + 9'd1;
                        end
                    end
                    default:
                    begin
                        if (b == HEAD_BYTE)
                        begin
                            phase_next    = PH_LEN;
                            position_next = 9'd1;
                            length_next   = '0;
                            type_next     = '0;
                            rx_seq_next   = '0;
                            crc_hi_next   = '0;
                            crc_next      = crc_byte(16'h0000, b);
                        end
                        else
                        begin
                            push            = 1'b1;
                            push_job.kind   = JOB_STATUS;
                            push_job.status = ST_HEAD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            position_reg  <= '0;
            length_reg    <= '0;
            seq_seen_reg  <= '0;
            seq_valid_reg <= 1'b0;
            type_reg      <= '0;
            crc_reg       <= '0;
            crc_hi_reg    <= '0;
            rx_seq_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            length_reg    <= length_next;
            seq_seen_reg  <= seq_seen_next;
            seq_valid_reg <= seq_valid_next;
            type_reg      <= type_next;
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
            rx_seq_reg    <= rx_seq_next;
        end
    end

endmodule

/* hdl/crcfr_queue.sv */
module crcfr_queue #(
    parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crcfr_pkg::job_t push_job,
    input  logic            pop,
    output crcfr_pkg::job_t head_job,
    output logic            full,
    output logic            nonempty
);
    import crcfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/crcfr_back.sv */
module crcfr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  crcfr_pkg::job_t      head_job,
    output logic                 pop,
    input  logic [7:0]           ack_type,
    output logic                 out_valid,
    input  logic                 out_stall,
    output crcfr_pkg::out_item_t out_data
);
    import crcfr_pkg::*;

    // Byte positions within the acknowledge frame
    localparam logic [2:0] ACK_HEAD   = 3'd0;
    localparam logic [2:0] ACK_LEN    = 3'd1;
    localparam logic [2:0] ACK_SEQ    = 3'd2;
    localparam logic [2:0] ACK_TYPE   = 3'd3;
    localparam logic [2:0] ACK_CRC_HI = 3'd4;
    localparam logic [2:0] ACK_CRC_LO = 3'd5;

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seq_reg, seq_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        advance;
    logic [7:0]  ack_byte;

    assign advance   = ~out_valid_reg | ~out_stall;
    assign pop       = advance & ~busy_reg & q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        unique case (idx_reg)
            ACK_HEAD:   ack_byte = HEAD_BYTE;
            ACK_LEN:    ack_byte = MIN_LEN;
            ACK_SEQ:    ack_byte = seq_reg;
            ACK_TYPE:   ack_byte = ack_type;
            ACK_CRC_HI: ack_byte = crc_reg[15:8];
            ACK_CRC_LO: ack_byte = crc_reg[7:0];
            default:    ack_byte = '0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (advance)
        begin
            if (busy_reg)
            begin
                out_valid_next         = 1'b1;
                out_data_next          = '0;
                out_data_next.out_kind = KIND_TX;
                out_data_next.out_byte = ack_byte;
                out_data_next.last     = (idx_reg == ACK_CRC_LO);
                if (idx_reg < ACK_CRC_HI)
                begin
                    crc_next = crc_byte(crc_reg, ack_byte);
                end
                if (idx_reg == ACK_CRC_LO)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            else if (q_valid)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                if (head_job.kind == JOB_PAYLOAD)
                begin
                    out_data_next.out_kind = KIND_PAYLOAD;
                    out_data_next.out_byte = head_job.data;
                    out_data_next.last     = 1'b1;
                end
                else
                begin
                    out_data_next.out_kind     = KIND_STATUS;
                    out_data_next.frame_status = head_job.status;
                    out_data_next.msg_type     = head_job.msg_type;
                    out_data_next.frame_len    = head_job.frame_len;
                    out_data_next.last         = (head_job.kind == JOB_STATUS);
                end
                if (head_job.kind == JOB_STATUS_ACK)
                begin
                    busy_next = 1'b1;
                    idx_next  = ACK_HEAD;
                    crc_next  = '0;
                    seq_next  = head_job.data;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        seq_reg      <= seq_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* hdl/crc16_framed_serial_receiver.sv */
// Framed serial receiver: checks length-prefixed frames with a CRC-16 trailer.
// Input channel (in_valid/in_stall/in_data) carries one received byte or one
// inter-byte timeout event per transaction. Output channel (out_valid/
// out_stall/out_data) carries payload bytes as they arrive, one status per
// finished frame, and after a good or duplicate frame the six acknowledge
// bytes to transmit; last marks the final result of each input transaction.
// The first result of an input passes a queue entry, then the output register.
// Throughput: one input per cycle while in_stall is low; results leave at one
// per cycle while out_stall is low, so an acknowledged frame holds the output
// stage for its status and six acknowledge bytes. A queue of QUEUE_DEPTH
// entries between the frame parser and the result sequencer absorbs that
// burst; in_stall rises only while the queue is full.
// When the receiver holds out_stall, the output register keeps its
// transaction, the sequencer waits, and the queue fills before input stalls.
// Reset returns the parser to head hunting, forgets the last sequence number,
// empties the queue and clears ack_type to zero. ack_type is written through
// the APB port at address 0 and should be changed only while the block idles.
module crc16_framed_serial_receiver #(
    parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  crcfr_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output crcfr_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import crcfr_pkg::*;

    localparam logic ACK_TYPE_INDEX = 1'b0;

    logic [7:0] ack_type_val_reg;
    logic       cfg_write;

    logic       q_full;
    logic       q_nonempty;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == ACK_TYPE_INDEX);
    assign prdata    = (paddr[2] == ACK_TYPE_INDEX) ? {24'h0, ack_type_val_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_type_val_reg <= '0;
        end
        else if (cfg_write)
        begin
            ack_type_val_reg <= pwdata[7:0];
        end
    end

    crcfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    crcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    crcfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .head_job  (head_job),
        .pop       (pop),
        .ack_type  (ack_type_val_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* tb/tb_top.sv */
module tb_top;

    import crcfr_pkg::*;

    localparam logic       OP_BYTE      = 1'b0;
    localparam logic       OP_TIMEOUT   = 1'b1;
    localparam logic [2:0] REG_ACK_TYPE = 3'd0;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 400;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } rx_phase_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    crc16_framed_serial_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Receiver's copy of the block state.
    rx_phase_t   rx_phase      = PH_HUNT;
    logic [8:0]  rx_pos        = '0;
    logic [7:0]  rx_len        = '0;
    logic [7:0]  seq_seen      = '0;
    logic        seq_known     = 1'b0;
    logic [7:0]  rx_type       = '0;
    logic [15:0] rx_crc        = '0;
    logic [7:0]  rx_crc_hi     = '0;
    logic [7:0]  rx_seq        = '0;
    logic [7:0]  ack_type_cfg  = '0;

    out_item_t   pending_results[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b0;
    bit          stall_pattern  = 1'b0;
    bit          hold_req       = 1'b0;
    logic [7:0]  last_seq       = '0;
    int          big_frames     = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0] b);
        logic [15:0] c;
        logic [15:0] d;
        c = crc_in;
        d = {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15] ^ d[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
            d = {d[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic out_item_t make_result(input logic [1:0] kind, input logic [7:0] b,
                                              input logic [2:0] st, input logic [7:0] mt,
                                              input logic [7:0] fl);
        out_item_t r;
        r.out_kind     = kind;
        r.out_byte     = b;
        r.frame_status = st;
        r.msg_type     = mt;
        r.frame_len    = fl;
        r.last         = 1'b0;
        return r;
    endfunction

    // Advances the receiver copy by one transaction and queues what it should emit.
    function automatic void decode_rx_item(input in_item_t it);
        out_item_t   batch[$];
        logic [7:0]  b;
        logic [8:0]  p;
        logic [2:0]  st;
        bit          ack;
        logic [15:0] c;
        logic [7:0]  fr[6];
        b = it.rx_byte;
        if (it.opcode == OP_TIMEOUT)
        begin
            if (rx_phase != PH_HUNT)
            begin
                batch.push_back(make_result(KIND_STATUS, 8'h00, ST_TIMEOUT, rx_type, rx_len));
                rx_phase = PH_HUNT;
                rx_pos   = '0;
            end
        end
        else if (rx_phase == PH_HUNT)
        begin
            if (b == HEAD_BYTE)
            begin
                rx_phase  = PH_LEN;
                rx_pos    = 9'd1;
                rx_len    = '0;
                rx_type   = '0;
                rx_seq    = '0;
                rx_crc_hi = '0;
                rx_crc    = crc16_update(16'h0000, b);
            end
            else
            begin
                batch.push_back(make_result(KIND_STATUS, 8'h00, ST_HEAD, 8'h00, 8'h00));
            end
        end
        else if (rx_phase == PH_LEN)
        begin
            rx_len = b;
            if (b < MIN_LEN)
            begin
                batch.push_back(make_result(KIND_STATUS, 8'h00, ST_LEN, 8'h00, b));
                rx_phase = PH_HUNT;
                rx_pos   = '0;
            end
            else
            begin
                rx_crc   = crc16_update(rx_crc, b);
                rx_pos   = 9'd2;
                rx_phase = PH_BODY;
            end
        end
        else
        begin
            p = rx_pos;
            if (p < {1'b0, rx_len})
            begin
                rx_crc = crc16_update(rx_crc, b);
            end
            if (p == 9'd2)
            begin
                rx_seq = b;
            end
            else if (p == 9'd3)
            begin
                rx_type = b;
            end
            else if (p < {1'b0, rx_len})
            begin
                batch.push_back(make_result(KIND_PAYLOAD, b, ST_GOOD, 8'h00, 8'h00));
            end
            else if (p == {1'b0, rx_len})
            begin
                rx_crc_hi = b;
            end

            if (p >= {1'b0, rx_len} + 9'd1)
            begin
                ack = 1'b1;
                // A repeated sequence number wins over a bad checksum.
                if (seq_known && rx_seq == seq_seen)
                begin
                    st = ST_DUP;
                end
                else
                begin
                    seq_seen  = rx_seq;
                    seq_known = 1'b1;
                    if (rx_crc_hi == rx_crc[15:8] && b == rx_crc[7:0])
                    begin
                        st = ST_GOOD;
                    end
                    else
                    begin
                        st  = ST_CRC;
                        ack = 1'b0;
                    end
                end
                batch.push_back(make_result(KIND_STATUS, 8'h00, st, rx_type, rx_len));
                if (ack)
                begin
                    fr[0] = HEAD_BYTE;
                    fr[1] = MIN_LEN;
                    fr[2] = seq_seen;
                    fr[3] = ack_type_cfg;
                    c = 16'h0000;
                    for (int i = 0; i < 4; i++)
                    begin
                        c = crc16_update(c, fr[i]);
                    end
                    fr[4] = c[15:8];
                    fr[5] = c[7:0];
                    for (int i = 0; i < 6; i++)
                    begin
                        batch.push_back(make_result(KIND_TX, fr[i], ST_GOOD, 8'h00, 8'h00));
                    end
                end
                rx_phase = PH_HUNT;
                rx_pos   = '0;
            end
            else
            begin
                rx_pos = p + 9'd1;
            end
        end
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i])
        begin
            pending_results.push_back(batch[i]);
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: kind 0x%0h byte 0x%0h",
                       out_data.out_kind, out_data.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("out_kind", want.out_kind, out_data.out_kind);
                compare_field("out_byte", want.out_byte, out_data.out_byte);
                compare_field("frame_status", want.frame_status, out_data.frame_status);
                compare_field("msg_type", want.msg_type, out_data.msg_type);
                compare_field("frame_len", want.frame_len, out_data.frame_len);
                compare_field("last", want.last, out_data.last);
            end
        end
    end

    // Receiver side: long hold-off on request, else alternating runs if enabled.
    initial
    begin
        bit stall_now;
        int stall_run;
        stall_now = 1'b0;
        stall_run = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!stall_pattern)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (stall_run == 0)
                begin
                    stall_now = ~stall_now;
                    stall_run = stall_now ? $urandom_range(1, 4) : $urandom_range(1, 10);
                end
                stall_run--;
                out_stall <= stall_now;
            end
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        decode_rx_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.opcode  = OP_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_timeout();
        in_item_t it;
        it.opcode  = OP_TIMEOUT;
        it.rx_byte = 8'($urandom);
        send_item(it);
    endtask

    // Sends a frame; a cut of zero or more, but under the frame size, stops after
    // that many bytes and follows with a timeout.
    task automatic send_frame(input logic [7:0] seq_no, input logic [7:0] mtype,
                              input logic [7:0] flen, input bit bad_crc, input int cut);
        logic [7:0]  fb[$];
        logic [15:0] c;
        int          n;
        fb = '{HEAD_BYTE, flen, seq_no, mtype};
        for (int i = 4; i < int'(flen); i++)
        begin
            fb.push_back(8'($urandom));
        end
        c = 16'h0000;
        foreach (fb[i])
        begin
            c = crc16_update(c, fb[i]);
        end
        if (bad_crc)
        begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        fb.push_back(c[15:8]);
        fb.push_back(c[7:0]);
        n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(fb[i]);
        end
        if (n < fb.size())
        begin
            send_timeout();
        end
        last_seq = seq_no;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ack_type(input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ACK_TYPE;
        pwdata  <= {24'h000000, val};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ack_type_cfg = val;
    endtask

    task automatic test_hunting_errors();
        gaps_on       = 1'b1;
        stall_pattern = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        // A timeout while hunting produces nothing.
        send_timeout();
        send_byte(HEAD_BYTE);
        send_byte(8'h00);
        send_byte(HEAD_BYTE);
        send_byte(8'h03);
        send_byte(HEAD_BYTE);
        send_timeout();
        wait_idle();
    endtask

    task automatic test_duplicate_and_timeout();
        // After reset the first frame is never a duplicate, even with sequence zero.
        send_frame(8'h00, 8'h5A, MIN_LEN, 1'b0, -1);
        send_frame(8'h00, 8'hA5, MIN_LEN, 1'b1, -1);
        send_frame(8'h80, 8'h33, 8'h06, 1'b0, 5);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] settings[3];
        int         stop;
        int         pick;
        logic [7:0] seq_no;
        logic [7:0] flen;
        settings[0] = 8'hFF;
        settings[1] = 8'($urandom);
        settings[2] = 8'h00;
        for (int ph = 0; ph < 3; ph++)
        begin
            write_ack_type(settings[ph]);
            gaps_on       = (ph != 0);
            stall_pattern = (ph != 0);
            stop = items_sent + 50;
            while (items_sent < stop)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_byte(8'($urandom_range(0, 254)) == HEAD_BYTE ?
                              8'h00 : 8'($urandom_range(0, 254)));
                end
                else if (pick < 12)
                begin
                    send_timeout();
                end
                else if (pick < 16)
                begin
                    send_byte(HEAD_BYTE);
                    send_byte(8'($urandom_range(0, 3)));
                end
                else
                begin
                    seq_no = ($urandom_range(0, 99) < 40) ? last_seq : 8'($urandom);
                    if (big_frames < 1 && $urandom_range(0, 99) < 2)
                    begin
                        flen = 8'hFF;
                        big_frames++;
                    end
                    else
                    begin
                        flen = 8'($urandom_range(4, 12));
                    end
                    if (pick < 24)
                    begin
                        send_frame(seq_no, 8'($urandom), flen, 1'b0,
                                   $urandom_range(1, int'(flen) + 1));
                    end
                    else
                    begin
                        send_frame(seq_no, 8'($urandom), flen,
                                   $urandom_range(0, 99) < 15, -1);
                    end
                end
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        gaps_on       = 1'b0;
        stall_pattern = 1'b1;
        hold_req      = 1'b1;
        // Payload bytes each take a queue entry, so these frames fill the queue.
        for (int i = 0; i < 4; i++)
        begin
            send_frame(last_seq + 8'd1, 8'($urandom), 8'd12, 1'b0, -1);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunting_errors();
        test_duplicate_and_timeout();
        test_random_traffic();
        test_backpressure();
        write_ack_type(8'h5C);
        test_duplicate_and_timeout();

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
